// ===== sv/pflm_pkg.sv =====
`default_nettype none

package pflm_pkg;

  // stream and field widths
  localparam int IN_W       = 48;
  localparam int OUT_W      = 48;
  localparam int USER_W     = 2;
  localparam int RANGE_W    = 16;
  localparam int TIME_W     = 32;
  localparam int BR_W       = 7;
  localparam int K_W        = 14;
  localparam int DRIVE_W    = 11;
  localparam int STAY_W     = 23;
  localparam int E_W        = 11;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 14;

  // behavior constants
  localparam int RANGE_MAX_MM  = 8200;
  localparam int NEAR_MM       = 2000;
  localparam int DWELL_MS      = 1000;
  localparam int FADE_MS       = 2000;
  localparam int K_LO          = 2700;
  localparam int K_HI          = 6500;
  localparam int BR_MAX        = 100;
  localparam int MIN_UPDATE_MS = 50;

  // shared multiplier operand and product widths
  localparam int A_W = 33;
  localparam int B_W = 28;
  localparam int P_W = A_W + B_W;
  localparam int X_W = 33;
  localparam int Q_W = 25;

  // reciprocal scaling: quotient is product >> DIV_K, or >> DIV_K_FULL for PWM_FULL
  localparam int DIV_K      = 32;
  localparam int DIV_K_FULL = 33;

  // constant divisors split into a power of two and an odd part
  localparam int SH_FADE  = 4;
  localparam int SH_STAY  = 3;
  localparam int SH_KSPAN = 3;
  localparam int SH_PCT   = 2;
  localparam int D_FADE   = FADE_MS >> SH_FADE;
  localparam int D_STAY   = DWELL_MS >> SH_STAY;
  localparam int D_KSPAN  = (K_HI - K_LO) >> SH_KSPAN;
  localparam int D_PCT    = BR_MAX >> SH_PCT;

  localparam logic [B_W-1:0] MAG_FADE  = B_W'((64'd1 << DIV_K) / D_FADE);
  localparam logic [B_W-1:0] MAG_STAY  = B_W'((64'd1 << DIV_K) / D_STAY);
  localparam logic [B_W-1:0] MAG_KSPAN = B_W'((64'd1 << DIV_K) / D_KSPAN);
  localparam logic [B_W-1:0] MAG_PCT   = B_W'((64'd1 << DIV_K) / D_PCT);

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MAN_BR  = 3'd0,
    CFG_MAN_K   = 3'd1,
    CFG_ADV_BR  = 3'd2,
    CFG_ADV_K   = 3'd3,
    CFG_AUTO    = 3'd4,
    CFG_POLY    = 3'd5,
    CFG_SENSOR  = 3'd6
  } cfg_idx_t;

endpackage

`default_nettype wire

// ===== sv/presence_fade_lamp_mixer_top.sv =====
`default_nettype none

// Lamp mixer driven by distance samples. Each item carries a range in mm and a
// millisecond timestamp; it yields at most one result item (drive values,
// diffuser level, stay length). Samples beyond 8200 mm with the sensor enabled
// are dropped and give no result. Items are handled one at a time by a small
// sequencer around one shared 33x28 multiplier and one 32-bit subtractor. In
// auto mode with the sensor enabled each item runs the brightness and colour
// temperature fade jobs (and the stay length when a stay ends) before the drive
// jobs; manual mode and the path without the sensor skip the fade jobs, and the
// drive jobs are skipped when the 50 ms update limit holds the drive back. All
// multiplies and reciprocal divides use that one multiplier. A finished result
// waits in an output register, so the next item can be taken while the result
// is still pending; a stalled output holds the sequencer until it frees up.
module presence_fade_lamp_mixer_top #(
  parameter int PWM_FULL = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // range_mm [15:0], now_ms [47:16]
  input  logic [pflm_pkg::IN_W-1:0]         in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // cold_drive [10:0], warm_drive [21:11], diffuser_level [22],
  // stay_seconds [45:23], zero [47:46]
  output logic [pflm_pkg::OUT_W-1:0]        out_tdata,
  // drive_valid [0], stay_valid [1]
  output logic [pflm_pkg::USER_W-1:0]       out_tuser,
  input  logic                              cfg_we,
  input  logic [pflm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [pflm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import pflm_pkg::*;

  localparam int F_W = $clog2(PWM_FULL + 1);
  localparam logic [B_W-1:0] MAG_FULL = B_W'((64'd1 << DIV_K_FULL) / PWM_FULL);
  localparam logic [Q_W-1:0] FULL_Q   = Q_W'(PWM_FULL);

  typedef enum logic [3:0] {
    S_IDLE, S_TARR, S_TLV, S_TFADE, S_MUL, S_DIV0, S_DIV1, S_DIV2, S_TLAST, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    J_BR, J_K, J_STAY, J_TV, J_BV, J_PC, J_PW
  } job_t;

  state_t state_r;
  job_t   job_r;

  // configuration
  logic [BR_W-1:0] man_br_r, adv_br_r;
  logic [K_W-1:0]  man_k_r, adv_k_r;
  logic            auto_r, poly_r, sens_r;

  // presence and timer state
  logic              near_r, arr_armed_r, lv_armed_r, diff_r;
  logic [TIME_W-1:0] arr_time_r, lv_time_r, fade_start_r, last_drive_r;

  // per-item work registers
  logic [TIME_W-1:0]  now_r, d_r;
  logic               near_smp_r;
  logic [E_W-1:0]     e_r;
  logic [BR_W-1:0]    br_r;
  logic [K_W-1:0]     k_r;
  logic [F_W-1:0]     tv_r, bv_r;
  logic [X_W-1:0]     x_r;
  logic [Q_W-1:0]     q_r;
  logic [P_W-1:0]     prod_r;
  logic               drive_r, stay_v_r;
  logic [STAY_W-1:0]  stay_s_r;
  logic [DRIVE_W-1:0] cold_r, warm_r;

  // output register
  logic               out_tvalid_r, out_dv_r, out_sv_r, out_diff_r;
  logic [DRIVE_W-1:0] out_cold_r, out_warm_r;
  logic [STAY_W-1:0]  out_stay_r;

  logic [RANGE_W-1:0] in_range;
  logic [TIME_W-1:0]  in_now;
  logic [TIME_W-1:0]  sub_b, sub_res;
  logic [K_W-1:0]     fd_from, fd_to, fd_mag, fd_new;
  logic [K_W:0]       fd_dif;
  logic               fd_neg;
  logic [BR_W-1:0]    br_c;
  logic [K_W-1:0]     k_c;
  logic [X_W-1:0]     div_d;
  logic [B_W-1:0]     div_mag;
  logic [2:0]         div_sh;
  logic               div_full;
  logic [X_W-1:0]     x_cur, rem;
  logic [Q_W-1:0]     q0, q_fin, drv;
  logic [A_W-1:0]     mul_a;
  logic [B_W-1:0]     mul_b;
  logic [P_W-1:0]     mul_prod;

  assign in_range = in_tdata[RANGE_W-1:0];
  assign in_now   = in_tdata[RANGE_W +: TIME_W];

  // shared subtractor: elapsed time since one stored timestamp
  always_comb begin
    unique case (state_r)
      S_TARR:  sub_b = arr_time_r;
      S_TLV:   sub_b = lv_time_r;
      S_TFADE: sub_b = fade_start_r;
      S_TLAST: sub_b = last_drive_r;
      default: sub_b = '0;
    endcase
  end
  assign sub_res = now_r - sub_b;

  // fade endpoints, direction follows presence
  always_comb begin
    if (job_r == J_K) begin
      fd_from = near_r ? man_k_r : adv_k_r;
      fd_to   = near_r ? adv_k_r : man_k_r;
    end else begin
      fd_from = K_W'(near_r ? man_br_r : adv_br_r);
      fd_to   = K_W'(near_r ? adv_br_r : man_br_r);
    end
    fd_dif = {1'b0, fd_to} - {1'b0, fd_from};
    fd_neg = fd_dif[K_W];
    fd_mag = fd_neg ? K_W'(-fd_dif) : fd_dif[K_W-1:0];
    fd_new = fd_neg ? fd_from - K_W'(q_fin) : fd_from + K_W'(q_fin);
  end

  // clamped drive inputs
  assign br_c = (br_r > BR_W'(BR_MAX)) ? BR_W'(BR_MAX) : br_r;
  always_comb begin
    if (k_r < K_W'(K_LO))      k_c = K_W'(K_LO);
    else if (k_r > K_W'(K_HI)) k_c = K_W'(K_HI);
    else                       k_c = k_r;
  end

  // divisor, reciprocal and pre-shift of the current job
  always_comb begin
    div_full = 1'b0;
    unique case (job_r)
      J_BR, J_K: begin
        div_d = X_W'(D_FADE);  div_mag = MAG_FADE;  div_sh = 3'(SH_FADE);
      end
      J_STAY: begin
        div_d = X_W'(D_STAY);  div_mag = MAG_STAY;  div_sh = 3'(SH_STAY);
      end
      J_TV: begin
        div_d = X_W'(D_KSPAN); div_mag = MAG_KSPAN; div_sh = 3'(SH_KSPAN);
      end
      J_BV: begin
        div_d = X_W'(D_PCT);   div_mag = MAG_PCT;   div_sh = 3'(SH_PCT);
      end
      J_PC, J_PW: begin
        div_d = X_W'(PWM_FULL); div_mag = MAG_FULL; div_sh = 3'd0; div_full = 1'b1;
      end
      default: begin
        div_d = X_W'(D_FADE);  div_mag = MAG_FADE;  div_sh = 3'd0;
      end
    endcase
  end

  // reciprocal divide: estimate, back-multiply, one-step correction
  assign x_cur = (job_r == J_STAY) ? X_W'(d_r >> SH_STAY) : X_W'(prod_r >> div_sh);
  assign q0    = div_full ? prod_r[DIV_K_FULL +: Q_W] : prod_r[DIV_K +: Q_W];
  assign rem   = x_r - prod_r[X_W-1:0];
  assign q_fin = q_r + Q_W'(rem >= div_d);
  assign drv   = FULL_Q - q_fin;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MUL: begin
        unique case (job_r)
          J_BR, J_K: begin mul_a = A_W'(fd_mag); mul_b = B_W'(e_r); end
          J_TV: begin
            mul_a = A_W'(k_c - K_W'(K_LO));
            mul_b = B_W'(PWM_FULL);
          end
          J_BV: begin mul_a = A_W'(br_c); mul_b = B_W'(PWM_FULL); end
          J_PC: begin mul_a = A_W'(tv_r); mul_b = B_W'(bv_r); end
          J_PW: begin mul_a = A_W'(F_W'(PWM_FULL) - tv_r); mul_b = B_W'(bv_r); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_DIV0: begin mul_a = A_W'(x_cur); mul_b = div_mag; end
      S_DIV1: begin mul_a = A_W'(q0); mul_b = B_W'(div_d); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_prod = {{B_W{1'b0}}, mul_a} * {{A_W{1'b0}}, mul_b};

  // product register
  always_ff @(posedge clk) begin
    prod_r <= mul_prod;
  end

  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      job_r        <= J_BR;
      man_br_r     <= BR_W'(80);
      man_k_r      <= K_W'(4000);
      adv_br_r     <= BR_W'(80);
      adv_k_r      <= K_W'(4000);
      auto_r       <= 1'b1;
      poly_r       <= 1'b0;
      sens_r       <= 1'b1;
      near_r       <= 1'b0;
      arr_armed_r  <= 1'b0;
      lv_armed_r   <= 1'b0;
      diff_r       <= 1'b1;
      arr_time_r   <= '0;
      lv_time_r    <= '0;
      fade_start_r <= '0;
      last_drive_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_addr))
          CFG_MAN_BR: man_br_r <= cfg_wdata[BR_W-1:0];
          CFG_MAN_K:  man_k_r  <= cfg_wdata[K_W-1:0];
          CFG_ADV_BR: adv_br_r <= cfg_wdata[BR_W-1:0];
          CFG_ADV_K:  adv_k_r  <= cfg_wdata[K_W-1:0];
          CFG_AUTO:   auto_r   <= cfg_wdata[0];
          CFG_POLY:   poly_r   <= cfg_wdata[0];
          CFG_SENSOR: sens_r   <= cfg_wdata[0];
          default: ;
        endcase
      end

      // output register empties unless a new result is loaded this cycle
      if (out_tvalid_r && out_tready && state_r != S_DONE) out_tvalid_r <= 1'b0;

      unique case (state_r)
        // take an item; drop far samples, short path without sensor
        S_IDLE: begin
          if (in_tvalid) begin
            now_r      <= in_now;
            near_smp_r <= (in_range < RANGE_W'(NEAR_MM));
            stay_v_r   <= 1'b0;
            stay_s_r   <= '0;
            if (sens_r) begin
              if (!(in_range > RANGE_W'(RANGE_MAX_MM))) state_r <= S_TARR;
            end else begin
              br_r    <= auto_r ? adv_br_r : man_br_r;
              k_r     <= auto_r ? adv_k_r : man_k_r;
              diff_r  <= !(auto_r && poly_r);
              state_r <= S_TLAST;
            end
          end
        end
        S_TARR: begin
          d_r     <= sub_res;
          state_r <= S_TLV;
        end
        // presence tracking with arrive and leave timers
        S_TLV: begin
          if (auto_r) begin
            if (near_smp_r && !near_r) begin
              if (!arr_armed_r) begin
                arr_armed_r <= 1'b1;
                arr_time_r  <= now_r;
              end else if (d_r >= TIME_W'(DWELL_MS)) begin
                fade_start_r <= now_r;
                near_r       <= 1'b1;
                lv_armed_r   <= 1'b0;
              end
            end else if (!near_smp_r && near_r) begin
              if (!lv_armed_r) begin
                lv_armed_r <= 1'b1;
                lv_time_r  <= now_r;
              end else if (sub_res >= TIME_W'(DWELL_MS)) begin
                fade_start_r <= now_r;
                near_r       <= 1'b0;
                stay_v_r     <= 1'b1;
                arr_armed_r  <= 1'b0;
              end
            end else if (near_smp_r) begin
              lv_armed_r <= 1'b0;
            end else begin
              arr_armed_r <= 1'b0;
            end
          end
          state_r <= S_TFADE;
        end
        // fade position and diffuser
        S_TFADE: begin
          e_r <= (sub_res > TIME_W'(FADE_MS)) ? E_W'(FADE_MS) : sub_res[E_W-1:0];
          if (auto_r) begin
            diff_r  <= near_r ? !poly_r : 1'b1;
            job_r   <= J_BR;
            state_r <= S_MUL;
          end else begin
            br_r    <= man_br_r;
            k_r     <= man_k_r;
            state_r <= S_TLAST;
          end
        end
        S_MUL: state_r <= S_DIV0;
        S_DIV0: begin
          x_r     <= x_cur;
          state_r <= S_DIV1;
        end
        S_DIV1: begin
          q_r     <= q0;
          state_r <= S_DIV2;
        end
        // quotient ready: write back and pick the next job
        S_DIV2: begin
          unique case (job_r)
            J_BR: begin
              br_r    <= fd_new[BR_W-1:0];
              job_r   <= J_K;
              state_r <= S_MUL;
            end
            J_K: begin
              k_r <= fd_new;
              if (stay_v_r) begin
                job_r   <= J_STAY;
                state_r <= S_DIV0;
              end else begin
                state_r <= S_TLAST;
              end
            end
            J_STAY: begin
              stay_s_r <= q_fin[STAY_W-1:0];
              state_r  <= S_TLAST;
            end
            J_TV: begin
              tv_r    <= q_fin[F_W-1:0];
              job_r   <= J_BV;
              state_r <= S_MUL;
            end
            J_BV: begin
              bv_r    <= q_fin[F_W-1:0];
              job_r   <= J_PC;
              state_r <= S_MUL;
            end
            J_PC: begin
              cold_r  <= drv[DRIVE_W-1:0];
              job_r   <= J_PW;
              state_r <= S_MUL;
            end
            J_PW: begin
              warm_r  <= drv[DRIVE_W-1:0];
              state_r <= S_DONE;
            end
            default: state_r <= S_DONE;
          endcase
        end
        // drive rate limit
        S_TLAST: begin
          if (sub_res > TIME_W'(MIN_UPDATE_MS)) begin
            last_drive_r <= now_r;
            drive_r      <= 1'b1;
            job_r        <= J_TV;
            state_r      <= S_MUL;
          end else begin
            drive_r <= 1'b0;
            cold_r  <= '0;
            warm_r  <= '0;
            state_r <= S_DONE;
          end
        end
        // hand the result to the output register once it is free
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_dv_r     <= drive_r;
            out_sv_r     <= stay_v_r;
            out_cold_r   <= cold_r;
            out_warm_r   <= warm_r;
            out_diff_r   <= diff_r;
            out_stay_r   <= stay_s_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_stay_r, out_diff_r, out_warm_r, out_cold_r};
  assign out_tuser  = {out_sv_r, out_dv_r};

endmodule

`default_nettype wire

// ===== sv/pflm_checker.sv =====
`default_nettype none

module pflm_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [pflm_pkg::OUT_W-1:0]    out_tdata,
  input wire logic [pflm_pkg::USER_W-1:0]   out_tuser
);
  import pflm_pkg::*;

  // drive fields are zero when no drive is issued
  a_drive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[2*DRIVE_W-1:0] == '0))
    else $error("drive fields nonzero without drive_valid");

  // stay length is zero when no stay ended
  a_stay_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[1]) |-> (out_tdata[2*DRIVE_W+1 +: STAY_W] == '0))
    else $error("stay_seconds nonzero without stay_valid");

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result item changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result item present after reset");

  // a new result appears only as the sequencer finishes an item
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result item appeared while block was idle");

endmodule

bind presence_fade_lamp_mixer_top pflm_checker u_pflm_checker (.*);

`default_nettype wire
